### src/ftp_rpl_pkg.sv
package ftp_rpl_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CODE_W   = 10;
    localparam int unsigned IP_W     = 32;
    localparam int unsigned PORT_W   = 16;
    localparam int unsigned ADDR_TOK = 6;

    localparam logic [CODE_W-1:0] PASV_CODE = 10'd227;

    localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    // Position of the byte within the parentheses of a passive reply
    typedef enum logic [1:0] {
        PAREN_BEFORE = 2'd0,
        PAREN_INSIDE = 2'd1,
        PAREN_AFTER  = 2'd2
    } t_paren;

endpackage

### src/ftp_rpl_byte_if.sv
interface ftp_rpl_byte_if;
    import ftp_rpl_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### src/ftp_rpl_res_if.sv
interface ftp_rpl_res_if;
    import ftp_rpl_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] reply_code;
    logic              code_ok;
    logic              is_passive;
    logic              addr_ok;
    logic [IP_W-1:0]   host_ip;
    logic [PORT_W-1:0] host_port;

    modport source (
        output valid, output reply_code, output code_ok, output is_passive,
        output addr_ok, output host_ip, output host_port, input ready
    );
    modport sink (
        input valid, input reply_code, input code_ok, input is_passive,
        input addr_ok, input host_ip, input host_port, output ready
    );
endinterface

### src/ftp_reply_line_parser.sv
// FTP control reply parser.
// i_rx carries the control-channel byte stream, one byte per transfer.
// o_res carries one result per completed reply line (at its LF): the reply
// code, a digits flag, the passive flag and, for a 227 reply, the IPv4
// address and port found between the parentheses.
// Lines shorter than three characters and continuation lines ("xyz-")
// produce no result.
// Throughput: one byte per cycle while i_rx.ready is high. Each byte updates
// the line state in the cycle it is taken; the result of an LF sits in the
// output register in the cycle after the LF transfer.
// The output register decouples the two sides: a new byte is taken while a
// result waits as long as o_res.ready is high; while a waiting result is
// stalled by o_res.ready low, i_rx.ready stays low for every byte.
// Reset (synchronous, active low) clears the line state and drops any
// pending result; the first byte after reset starts a new line.
module ftp_reply_line_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ftp_rpl_byte_if.sink     i_rx,
    ftp_rpl_res_if.source    o_res
);
    import ftp_rpl_pkg::*;

    // line state
    logic [2:0]        r_pos,       n_pos;
    logic [CODE_W-1:0] r_code,      n_code;
    logic              r_code_good, n_code_good;
    logic              r_cont,      n_cont;
    logic              r_cr,        n_cr;
    t_paren            r_paren,     n_paren;
    logic [2:0]        r_tok_idx,   n_tok_idx;
    logic [8:0]        r_tok_val,   n_tok_val;
    logic              r_tok_on,    n_tok_on;
    logic [7:0]        r_tok [ADDR_TOK];
    logic [7:0]        n_tok [ADDR_TOK];
    logic              r_addr_err,  n_addr_err;

    // result register
    logic              r_out_valid, n_out_valid;
    logic [CODE_W-1:0] r_res_code,  n_res_code;
    logic              r_res_cok,   n_res_cok;
    logic              r_res_pasv,  n_res_pasv;
    logic              r_res_aok,   n_res_aok;
    logic [IP_W-1:0]   r_res_ip,    n_res_ip;
    logic [PORT_W-1:0] r_res_port,  n_res_port;

    logic              rx_take;
    logic [BYTE_W-1:0] b;
    logic              is_digit;
    logic [3:0]        digit;
    logic [13:0]       code_mul;
    logic [12:0]       tok_mul;
    logic              close_tok;
    logic              too_short;
    logic              drop_line;
    logic              cok;
    logic              pasv;
    logic              aok;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign rx_take    = i_rx.valid && i_rx.ready;

    assign b        = i_rx.rx_byte;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign digit    = b[3:0];
    assign code_mul = {1'b0, r_code, 3'b000} + {3'b000, r_code, 1'b0} + {10'd0, digit};
    assign tok_mul  = {1'b0, r_tok_val, 3'b000} + {3'b000, r_tok_val, 1'b0}
                    + {9'd0, digit};

    // line completion checks
    assign too_short = (r_pos < 3'd3) || ((r_pos == 3'd3) && r_cr);
    assign drop_line = too_short || r_cont;
    assign cok       = r_code_good;
    assign pasv      = cok && (r_code == PASV_CODE);
    assign aok       = pasv && (r_paren == PAREN_AFTER) && !r_addr_err
                     && (r_tok_idx >= 3'(ADDR_TOK));

    // a comma or the closing parenthesis ends the current token
    assign close_tok = (r_paren == PAREN_INSIDE) && r_tok_on
                     && ((b == CH_COMMA) || (b == CH_CLOSE));

    // next line state and result
    always_comb begin
        n_pos       = r_pos;
        n_code      = r_code;
        n_code_good = r_code_good;
        n_cont      = r_cont;
        n_cr        = r_cr;
        n_paren     = r_paren;
        n_tok_idx   = r_tok_idx;
        n_tok_val   = r_tok_val;
        n_tok_on    = r_tok_on;
        n_tok       = r_tok;
        n_addr_err  = r_addr_err;

        n_out_valid = r_out_valid && !o_res.ready;
        n_res_code  = r_res_code;
        n_res_cok   = r_res_cok;
        n_res_pasv  = r_res_pasv;
        n_res_aok   = r_res_aok;
        n_res_ip    = r_res_ip;
        n_res_port  = r_res_port;

        if (rx_take) begin
            if (b == CH_LF) begin
                // emit the line result, then start a fresh line
                if (!drop_line) begin
                    n_out_valid = 1'b1;
                    n_res_code  = cok ? r_code : '0;
                    n_res_cok   = cok;
                    n_res_pasv  = pasv;
                    n_res_aok   = aok;
                    n_res_ip    = aok ? {r_tok[0], r_tok[1], r_tok[2], r_tok[3]} : '0;
                    n_res_port  = aok ? {r_tok[4], r_tok[5]} : '0;
                end
                n_pos       = '0;
                n_code      = '0;
                n_code_good = 1'b1;
                n_cont      = 1'b0;
                n_cr        = 1'b0;
                n_paren     = PAREN_BEFORE;
                n_tok_idx   = '0;
                n_tok_val   = '0;
                n_tok_on    = 1'b0;
                for (int k = 0; k < ADDR_TOK; k++) begin
                    n_tok[k] = '0;
                end
                n_addr_err  = 1'b0;
            end else begin
                // reply code and continuation mark
                if (r_pos < 3'd3) begin
                    if (is_digit) begin
                        n_code = code_mul[CODE_W-1:0];
                    end else begin
                        n_code_good = 1'b0;
                    end
                end else if ((r_pos == 3'd3) && (b == CH_DASH)) begin
                    n_cont = 1'b1;
                end

                // passive address tokens
                unique case (r_paren)
                    PAREN_BEFORE: begin
                        if (b == CH_OPEN) begin
                            n_paren = PAREN_INSIDE;
                        end
                    end
                    PAREN_INSIDE: begin
                        if (is_digit) begin
                            n_tok_val = (tok_mul > 13'd256) ? 9'd256 : tok_mul[8:0];
                            n_tok_on  = 1'b1;
                        end else if ((b == CH_COMMA) || (b == CH_CLOSE)) begin
                            if (b == CH_CLOSE) begin
                                n_paren = PAREN_AFTER;
                            end
                            if (close_tok) begin
                                if (r_tok_val[8]) begin
                                    n_addr_err = 1'b1;
                                end
                                for (int k = 0; k < ADDR_TOK; k++) begin
                                    if (r_tok_idx == 3'(k)) begin
                                        n_tok[k] = r_tok_val[7:0];
                                    end
                                end
                                if (r_tok_idx != 3'd7) begin
                                    n_tok_idx = r_tok_idx + 3'd1;
                                end
                                n_tok_val = '0;
                                n_tok_on  = 1'b0;
                            end
                        end else begin
                            n_addr_err = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase

                n_cr = (b == CH_CR);
                if (r_pos != 3'd7) begin
                    n_pos = r_pos + 3'd1;
                end
            end
        end
    end

    // hold state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_code      <= '0;
            r_code_good <= 1'b1;
            r_cont      <= 1'b0;
            r_cr        <= 1'b0;
            r_paren     <= PAREN_BEFORE;
            r_tok_idx   <= '0;
            r_tok_val   <= '0;
            r_tok_on    <= 1'b0;
            for (int k = 0; k < ADDR_TOK; k++) begin
                r_tok[k] <= '0;
            end
            r_addr_err  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_code      <= n_code;
            r_code_good <= n_code_good;
            r_cont      <= n_cont;
            r_cr        <= n_cr;
            r_paren     <= n_paren;
            r_tok_idx   <= n_tok_idx;
            r_tok_val   <= n_tok_val;
            r_tok_on    <= n_tok_on;
            r_tok       <= n_tok;
            r_addr_err  <= n_addr_err;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_res_code <= n_res_code;
        r_res_cok  <= n_res_cok;
        r_res_pasv <= n_res_pasv;
        r_res_aok  <= n_res_aok;
        r_res_ip   <= n_res_ip;
        r_res_port <= n_res_port;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.reply_code = r_res_code;
    assign o_res.code_ok    = r_res_cok;
    assign o_res.is_passive = r_res_pasv;
    assign o_res.addr_ok    = r_res_aok;
    assign o_res.host_ip    = r_res_ip;
    assign o_res.host_port  = r_res_port;

endmodule

### tb/ftp_reply_checker.sv
module ftp_reply_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ftp_rpl_byte_if i_rx,
    ftp_rpl_res_if  i_res,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_replies,
    output int      o_pasv_good
);
    import ftp_rpl_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] reply_code;
        logic              code_ok;
        logic              is_passive;
        logic              addr_ok;
        logic [IP_W-1:0]   host_ip;
        logic [PORT_W-1:0] host_port;
    } t_reply;

    // Predicted line state
    logic [2:0]            char_pos;
    logic [CODE_W-1:0]     code_acc;
    logic                  digits_good;
    logic                  dash_seen;
    logic                  cr_last;
    t_paren                paren;
    logic [2:0]            tok_idx;
    logic [8:0]            tok_val;
    logic                  tok_open;
    logic [8*ADDR_TOK-1:0] addr_bytes;
    logic                  addr_err;

    t_reply expected_replies[$];
    t_reply want_reply;
    t_reply got_reply;
    t_reply new_reply;
    logic   new_produced;

    int fail_count;
    int replies;
    int pasv_good;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_replies.size();
    assign o_replies    = replies;
    assign o_pasv_good  = pasv_good;

    task automatic clear_line_state();
        char_pos    = '0;
        code_acc    = '0;
        digits_good = 1'b1;
        dash_seen   = 1'b0;
        cr_last     = 1'b0;
        paren       = PAREN_BEFORE;
        tok_idx     = '0;
        tok_val     = '0;
        tok_open    = 1'b0;
        addr_bytes  = '0;
        addr_err    = 1'b0;
    endtask

    // Finish the current address token: range check, store if among the first six
    task automatic close_addr_token();
        int sh;
        if (tok_open) begin
            if (tok_val > 9'd255)
                addr_err = 1'b1;
            if (tok_idx < ADDR_TOK) begin
                sh = (int'(ADDR_TOK) - 1 - int'(tok_idx)) * 8;
                addr_bytes = addr_bytes | (48'(tok_val[7:0]) << sh);
            end
            if (tok_idx < 3'd7)
                tok_idx = tok_idx + 3'd1;
            tok_val  = '0;
            tok_open = 1'b0;
        end
    endtask

    // Advance the line state by one byte; on LF produce the reply if the line counts
    task automatic parse_reply_byte(input logic [BYTE_W-1:0] b, output logic produced,
                                    output t_reply r);
        logic short_line;
        logic is_digit;
        int   nv;
        produced = 1'b0;
        r        = '0;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        if (b == CH_LF) begin
            short_line = (char_pos < 3'd3) || (char_pos == 3'd3 && cr_last);
            if (!short_line && !dash_seen) begin
                produced     = 1'b1;
                r.code_ok    = digits_good;
                r.reply_code = digits_good ? code_acc : '0;
                r.is_passive = digits_good && (code_acc == PASV_CODE);
                r.addr_ok    = r.is_passive && (paren == PAREN_AFTER) && !addr_err &&
                               (tok_idx >= ADDR_TOK);
                if (r.addr_ok) begin
                    r.host_ip   = addr_bytes[47:16];
                    r.host_port = addr_bytes[15:0];
                end
            end
            clear_line_state();
        end else begin
            // Reply code and continuation dash
            if (char_pos < 3'd3) begin
                if (is_digit)
                    code_acc = CODE_W'(code_acc * 10 + (b - CH_ZERO));
                else
                    digits_good = 1'b0;
            end else if (char_pos == 3'd3 && b == CH_DASH) begin
                dash_seen = 1'b1;
            end
            // Passive address between the parentheses
            case (paren)
                PAREN_BEFORE: begin
                    if (b == CH_OPEN)
                        paren = PAREN_INSIDE;
                end
                PAREN_INSIDE: begin
                    if (is_digit) begin
                        nv       = int'(tok_val) * 10 + int'(b) - int'(CH_ZERO);
                        tok_val  = (nv > 256) ? 9'd256 : 9'(nv);
                        tok_open = 1'b1;
                    end else if (b == CH_COMMA) begin
                        close_addr_token();
                    end else if (b == CH_CLOSE) begin
                        close_addr_token();
                        paren = PAREN_AFTER;
                    end else begin
                        addr_err = 1'b1;
                    end
                end
                default: ;
            endcase
            cr_last = (b == CH_CR);
            if (char_pos < 3'd7)
                char_pos = char_pos + 3'd1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    initial begin
        fail_count = 0;
        replies    = 0;
        pasv_good  = 0;
        clear_line_state();
    end

    // Compare reply transfers first, then predict from the byte transfer of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line_state();
            expected_replies.delete();
        end else begin
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                got_reply = '{i_res.reply_code, i_res.code_ok, i_res.is_passive,
                              i_res.addr_ok, i_res.host_ip, i_res.host_port};
                if (expected_replies.size() == 0) begin
                    fail_count++;
                    $display({"%0t: reply mismatch: expected none, ",
                              "actual code %0d ip 0x%0h port %0d"},
                             $time, got_reply.reply_code, got_reply.host_ip,
                             got_reply.host_port);
                end else begin
                    want_reply = expected_replies.pop_front();
                    check_field("reply_code", 32'(want_reply.reply_code),
                                32'(got_reply.reply_code));
                    check_field("code_ok", 32'(want_reply.code_ok), 32'(got_reply.code_ok));
                    check_field("is_passive", 32'(want_reply.is_passive),
                                32'(got_reply.is_passive));
                    check_field("addr_ok", 32'(want_reply.addr_ok), 32'(got_reply.addr_ok));
                    check_field("host_ip", want_reply.host_ip, got_reply.host_ip);
                    check_field("host_port", 32'(want_reply.host_port),
                                32'(got_reply.host_port));
                    replies++;
                    if (want_reply.addr_ok)
                        pasv_good++;
                end
            end
            if (i_rx.valid === 1'b1 && i_rx.ready === 1'b1) begin
                parse_reply_byte(i_rx.rx_byte, new_produced, new_reply);
                if (new_produced)
                    expected_replies.insert(expected_replies.size(), new_reply);
            end
        end
    end

endmodule

### tb/testbench.sv
module testbench;
    import ftp_rpl_pkg::*;

    localparam int RANDOM_BYTES = 1700;
    localparam int HOLD_AT      = 1000;
    localparam int LONG_HOLD    = 400;
    localparam int PAUSE_AT     = 1800;
    localparam int SETTLE       = 8;
    localparam int CYCLE_LIMIT  = 600000;

    logic i_clk;
    logic i_rst_n;

    ftp_rpl_byte_if rx_ch ();
    ftp_rpl_res_if  res_ch ();

    int fail_count;
    int pending;
    int replies;
    int pasv_good;
    int bytes_sent;
    int cycles;
    int stall_left;
    int stop_at;
    bit drain;
    bit hold_done;
    bit paused;

    logic [BYTE_W-1:0] line_buf[$];

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    ftp_reply_line_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    ftp_reply_checker reply_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_replies    (replies),
        .o_pasv_good  (pasv_good)
    );

    // Mostly short idle gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] any_but_lf();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CH_LF)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Add one byte at the end of the line buffer
    task automatic append_byte(input logic [BYTE_W-1:0] v);
        line_buf.insert(line_buf.size(), v);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endtask

    task automatic put_num(input int n);
        put_str($sformatf("%0d", n));
    endtask

    task automatic end_line(input bit with_cr);
        if (with_cr)
            append_byte(CH_CR);
        append_byte(CH_LF);
    endtask

    task automatic put_line(input string s, input bit with_cr);
        put_str(s);
        end_line(with_cr);
    endtask

    // Printable filler text
    task automatic put_text(input int max_len);
        int n;
        n = $urandom_range(0, max_len);
        repeat (n)
            append_byte(8'($urandom_range(32, 126)));
    endtask

    task automatic put_digits();
        repeat (3)
            append_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    // Parenthesized address list with random defects
    task automatic put_addr_list();
        int ntok;
        int r;
        int v;
        if ($urandom_range(0, 9) != 0)
            append_byte(CH_OPEN);
        ntok = ($urandom_range(0, 9) < 8) ? 6 : $urandom_range(0, 9);
        for (int i = 0; i < ntok; i++) begin
            if ($urandom_range(0, 99) < 8)
                append_byte(CH_COMMA);
            r = $urandom_range(0, 99);
            if (r < 10)
                v = 0;
            else if (r < 20)
                v = 255;
            else if (r < 85)
                v = $urandom_range(0, 255);
            else if (r < 93)
                v = $urandom_range(256, 999);
            else
                v = $urandom_range(1000, 99999);
            if ($urandom_range(0, 99) < 5)
                put_str("00");
            put_num(v);
            if ($urandom_range(0, 99) < 4)
                append_byte(($urandom_range(0, 3) == 0) ? CH_CR :
                            8'($urandom_range(32, 43)));
            if (i < ntok - 1)
                append_byte(CH_COMMA);
        end
        if ($urandom_range(0, 99) < 5)
            append_byte(CH_COMMA);
        if ($urandom_range(0, 9) != 0)
            append_byte(CH_CLOSE);
        if ($urandom_range(0, 4) == 0)
            put_str("(9)");
    endtask

    // Build one random line: passive replies most often, plus other kinds and noise
    task automatic make_random_line();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            put_str("227");
            if ($urandom_range(0, 4) == 0)
                put_str(" )");
            put_str(" ");
            put_text(4);
            put_addr_list();
            put_text(3);
            end_line($urandom_range(0, 3) != 0);
        end else if (kind < 55) begin
            if ($urandom_range(0, 3) == 0)
                put_str("227");
            else
                put_digits();
            if ($urandom_range(0, 1) == 0) begin
                put_str(" ");
                put_text(8);
            end
            end_line($urandom_range(0, 3) != 0);
        end else if (kind < 65) begin
            if ($urandom_range(0, 1) == 0)
                put_str("227");
            else
                put_digits();
            append_byte(CH_DASH);
            if ($urandom_range(0, 1) == 0)
                put_str("(1,2,3,4,5,6)");
            put_text(6);
            end_line($urandom_range(0, 3) != 0);
        end else if (kind < 75) begin
            n = $urandom_range(0, 3);
            repeat (n)
                append_byte(any_but_lf());
            end_line($urandom_range(0, 1) != 0);
        end else if (kind < 85) begin
            repeat (3) begin
                if ($urandom_range(0, 1) == 0)
                    append_byte(8'(CH_ZERO + $urandom_range(0, 9)));
                else
                    append_byte(any_but_lf());
            end
            put_text(4);
            if ($urandom_range(0, 1) == 0)
                put_addr_list();
            end_line($urandom_range(0, 3) != 0);
        end else begin
            n = $urandom_range(1, 20);
            repeat (n)
                append_byte(8'($urandom_range(0, 255)));
            append_byte(CH_LF);
        end
    endtask

    // One byte transfer: optional idle gap, then hold valid until ready
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (rx_ch.ready !== 1'b1)
            @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line(input bit no_gaps);
        while (line_buf.size() > 0)
            send_byte(line_buf.pop_front(), no_gaps);
    endtask

    // Receiver: random stalls, one long hold, always ready while draining
    initial begin
        res_ch.ready = 1'b0;
        stall_left   = 0;
        hold_done    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (drain) begin
                res_ch.ready <= 1'b1;
            end else if (!hold_done && bytes_sent >= HOLD_AT) begin
                hold_done    = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    // Cycle limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
            @(posedge i_clk) cycles++;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        i_rst_n       = 1'b0;
        drain         = 1'b0;
        paused        = 1'b0;
        bytes_sent    = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines: extremes, drops and address defects
        put_line("227 (192,168,1,2,4,1)", 1'b1);
        put_line("227 (255,255,255,255,255,255)", 1'b0);
        put_line("227 (0,0,0,0,0,0)", 1'b1);
        put_line("227-(1,2,3,4,5,6)", 1'b1);
        put_line("", 1'b0);
        put_line("22", 1'b0);
        put_line("ab", 1'b1);
        put_line("abc", 1'b1);
        put_line("999 x", 1'b0);
        put_line("000", 1'b0);
        put_line("227 )(1,,2,3,4,5,6)(x)", 1'b1);
        put_line("227 (1,2,3,4,5,256)", 1'b0);
        put_line("227 (1,2,3,4,5,6,7)", 1'b0);
        put_line("227 (1,2,3,4,5,6,300)", 1'b0);
        put_line("227 (1,2,3,4,5)", 1'b0);
        put_line("227 (1,2,3,4,5,6", 1'b0);
        put_line("227 1,2,3,4,5,6)", 1'b0);
        put_str("227 (1,2,3,4,5,6");
        append_byte(CH_CR);
        put_line(")", 1'b0);
        put_line("227 (1,2, 3,4,5,6)", 1'b0);
        put_line("2a7 (1,2,3,4,5,6)", 1'b0);
        put_str("200 ");
        append_byte(8'hFF);
        append_byte(8'h80);
        end_line(1'b1);
        send_line(1'b0);

        // Random lines, with one drain pause of the sender
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            if (!paused && bytes_sent >= PAUSE_AT) begin
                paused = 1'b1;
                rx_ch.valid <= 1'b0;
                while (pending != 0)
                    @(negedge i_clk);
                @(negedge i_clk);
            end
            make_random_line();
            send_line($urandom_range(0, 3) == 0);
        end
        rx_ch.valid <= 1'b0;

        // Drain, then watch for stray replies
        while (pending != 0)
            @(negedge i_clk);
        drain = 1'b1;
        repeat (SETTLE) @(negedge i_clk);

        $display("Sent %0d control bytes; checked %0d replies, %0d with a good passive address.",
                 bytes_sent, replies, pasv_good);
        $display("Long receiver hold: %0d, sender drain pause: %0d.", hold_done, paused);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
